/* rtl/m4vt_pkg.sv */
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared widths, register indexes and types of the 4x4 matrix-vector block.
// ----------------------------------------------------------------------------
package m4vt_pkg;

	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int PAIR_W        = PROD_W + 1;
	localparam int SUM_W         = PROD_W + 2;
	localparam int NUM_ROWS      = 4;
	localparam int NUM_COLS      = 4;
	localparam int NUM_REGS      = 8;
	localparam int REG_W         = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int DEF_FRAC_BITS = 16;

	// register indexes: column c, row pair (0/1 or 2/3)
	localparam logic [CFG_IDX_W-1:0] REG_C0_R01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C0_R23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C1_R01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C1_R23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C2_R01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C2_R23 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_C3_R01 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_C3_R23 = 3'd7;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic [REG_W-1:0]         mreg_t;

	typedef struct packed {
		q_t   data;
		logic sat;
	} lane_res_t;

endpackage

/* rtl/m4vt_cfg.sv */
// ----------------------------------------------------------------------------
// m4vt_cfg
// Matrix register file; resets to the identity in the current Q format.
// ----------------------------------------------------------------------------
module m4vt_cfg
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output mreg_t                mreg [NUM_REGS]
);

	localparam mreg_t ONE_LO = REG_W'(64'd1 << FRAC_BITS);
	localparam mreg_t ONE_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));

	mreg_t mreg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mreg_q[REG_C0_R01] <= ONE_LO;
			mreg_q[REG_C0_R23] <= '0;
			mreg_q[REG_C1_R01] <= ONE_HI;
			mreg_q[REG_C1_R23] <= '0;
			mreg_q[REG_C2_R01] <= '0;
			mreg_q[REG_C2_R23] <= ONE_LO;
			mreg_q[REG_C3_R01] <= '0;
			mreg_q[REG_C3_R23] <= ONE_HI;
		end else if (cfg_we) begin
			mreg_q[cfg_index] <= cfg_data;
		end
	end

	assign mreg = mreg_q;

endmodule

/* rtl/m4vt_lane.sv */
// ----------------------------------------------------------------------------
// m4vt_lane
// One row lane: four products, two-level adder, floor shift and clip.
// ----------------------------------------------------------------------------
module m4vt_lane
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic      clk,
	input  q_t        elem [NUM_COLS],
	input  q_t        vec  [NUM_COLS],
	output lane_res_t res_s4
);

	logic signed [PROD_W-1:0] prod_s1 [NUM_COLS];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SUM_W-1:0]  shifted;
	logic                     fits;

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_COLS; c++) begin
			prod_s1[c] <= PROD_W'(elem[c]) * PROD_W'(vec[c]);
		end
	end

	always_ff @(posedge clk) begin
		pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
		pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		sum_s3     <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
	end

	// arithmetic shift floors negative sums
	assign shifted = sum_s3 >>> FRAC_BITS;
	// in range when all bits above the result's sign match it
	assign fits = (&shifted[SUM_W-1:DATA_W-1]) | ~(|shifted[SUM_W-1:DATA_W-1]);

	always_ff @(posedge clk) begin
		res_s4.sat <= ~fits;
		if (fits) begin
			res_s4.data <= shifted[DATA_W-1:0];
		end else begin
			res_s4.data <= shifted[SUM_W-1] ? Q_MIN : Q_MAX;
		end
	end

endmodule

/* rtl/m4vt_merge.sv */
// ----------------------------------------------------------------------------
// m4vt_merge
// Collects the four lane results into the output register and ORs the flags.
// ----------------------------------------------------------------------------
module m4vt_merge
	import m4vt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s4,
	input  lane_res_t lane_res [NUM_ROWS],
	output logic      done,
	output q_t        out_x,
	output q_t        out_y,
	output q_t        out_z,
	output q_t        out_w,
	output logic      saturated
);

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		out_x     <= lane_res[0].data;
		out_y     <= lane_res[1].data;
		out_z     <= lane_res[2].data;
		out_w     <= lane_res[3].data;
		saturated <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat | lane_res[3].sat;
	end

	assign done = done_q;

endmodule

/* rtl/mat4_vector_transform_top.sv */
// ----------------------------------------------------------------------------
// mat4_vector_transform_top
// Transforms Q16.16 4-vectors by a configured column-major 4x4 matrix.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-------------------------
//  input    | vec_x vec_y vec_z vec_w             | start && !busy
//  result   | out_x out_y out_z out_w saturated   | done, one-cycle strobe
//  config   | cfg_index cfg_data                  | cfg_we
//
// One vector per cycle; busy never rises. An accepted vector passes through the
// product stage, two adder stages, the shift/clip stage and the output
// register before done strobes. Reset clears the valid pipeline and loads the
// identity matrix. The receiver cannot stall, so nothing backs up.
module mat4_vector_transform_top
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  q_t                   vec_x,
	input  q_t                   vec_y,
	input  q_t                   vec_z,
	input  q_t                   vec_w,
	output logic                 done,
	output q_t                   out_x,
	output q_t                   out_y,
	output q_t                   out_z,
	output q_t                   out_w,
	output logic                 saturated,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	mreg_t     mreg [NUM_REGS];
	q_t        vec  [NUM_COLS];
	q_t        elem [NUM_ROWS][NUM_COLS];
	lane_res_t lane_res [NUM_ROWS];
	logic      accept;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	m4vt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mreg      (mreg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		// element (r, c) sits in register 2c + r/2, half r%2
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_elem
			assign elem[r][c] = mreg[c * 2 + r / 2][(r % 2) * DATA_W +: DATA_W];
		end

		m4vt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.elem   (elem[r]),
			.vec    (vec),
			.res_s4 (lane_res[r])
		);
	end

	m4vt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (valid_s4),
		.lane_res  (lane_res),
		.done      (done),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted transaction did not complete after five cycles");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(out_x == Q_MAX || out_x == Q_MIN || out_y == Q_MAX || out_y == Q_MIN ||
		 out_z == Q_MAX || out_z == Q_MIN || out_w == Q_MAX || out_w == Q_MIN))
		else $error("saturated flag without a clipped component");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s3, 2))
		else $error("result strobe without a transaction in flight");

endmodule
